[rtl/jvmos_pkg.sv]
// ----------------------------------------------------------------------------
// jvmos_pkg: shared types and constants of the JVM operand stack
// Item layouts, operation codes, status codes, cell shift codes and the
// table that maps each rearrangement form onto the entries it copies.
// ----------------------------------------------------------------------------
package jvmos_pkg;

  localparam logic [3:0] OP_PUSH    = 4'd0;
  localparam logic [3:0] OP_POP     = 4'd1;
  localparam logic [3:0] OP_POP2    = 4'd2;
  localparam logic [3:0] OP_DUP     = 4'd3;
  localparam logic [3:0] OP_DUP_X1  = 4'd4;
  localparam logic [3:0] OP_DUP_X2  = 4'd5;
  localparam logic [3:0] OP_DUP2    = 4'd6;
  localparam logic [3:0] OP_DUP2_X1 = 4'd7;
  localparam logic [3:0] OP_DUP2_X2 = 4'd8;
  localparam logic [3:0] OP_SWAP    = 4'd9;
  localparam logic [3:0] OP_CLEAR   = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [3:0] SEQ_NONE    = 4'd0;
  localparam logic [3:0] SEQ_PUSH    = 4'd1;
  localparam logic [3:0] SEQ_DUP     = 4'd2;
  localparam logic [3:0] SEQ_X1      = 4'd3;
  localparam logic [3:0] SEQ_X2      = 4'd4;
  localparam logic [3:0] SEQ_PAIR    = 4'd5;
  localparam logic [3:0] SEQ_PAIR_X1 = 4'd6;
  localparam logic [3:0] SEQ_PAIR_X2 = 4'd7;
  localparam logic [3:0] SEQ_SWAP    = 4'd8;

  localparam logic [2:0] SH_HOLD  = 3'd0;
  localparam logic [2:0] SH_DOWN1 = 3'd1;
  localparam logic [2:0] SH_DOWN2 = 3'd2;
  localparam logic [2:0] SH_UP1   = 3'd3;
  localparam logic [2:0] SH_UP2   = 3'd4;

  localparam int FILL_SLOTS = 6;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] push_value;
    logic        push_is_wide;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] top_value;
    logic        top_is_wide;
    logic [6:0]  depth;
  } rsp_item_t;

  typedef struct packed {
    logic [2:0] need;
    logic [2:0] nout;
    logic [3:0] seq;
    logic       clear;
  } dec_t;

  typedef struct packed {
    logic       update;
    logic [2:0] fill_count;
    logic [2:0] shift;
  } cell_ctl_t;

  // Source entry, counted from the old top, of new entry pos (top first).
  function automatic logic [1:0] seq_src(input logic [3:0] seq, input logic [2:0] pos);
    logic [1:0] k;
    k = 2'd0;
    case (seq)
      SEQ_X1:      k = (pos == 3'd1) ? 2'd1 : 2'd0;
      SEQ_X2: begin
        case (pos)
          3'd1:    k = 2'd1;
          3'd2:    k = 2'd2;
          default: k = 2'd0;
        endcase
      end
      SEQ_PAIR:    k = pos[0] ? 2'd1 : 2'd0;
      SEQ_PAIR_X1: begin
        case (pos) inside
          3'd1, 3'd4: k = 2'd1;
          3'd2:       k = 2'd2;
          default:    k = 2'd0;
        endcase
      end
      SEQ_PAIR_X2: begin
        case (pos) inside
          3'd1, 3'd5: k = 2'd1;
          3'd2:       k = 2'd2;
          3'd3:       k = 2'd3;
          default:    k = 2'd0;
        endcase
      end
      SEQ_SWAP:    k = (pos == 3'd0) ? 2'd1 : 2'd0;
      default:     k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

[rtl/jvmos_decode.sv]
// ----------------------------------------------------------------------------
// jvmos_decode: operation decoder
// Picks the form of an operation from the category flags of the top three
// entries and gives how many entries it consumes and produces.
// ----------------------------------------------------------------------------
module jvmos_decode (
  input  logic [3:0]      operation,
  input  logic [2:0]      wide,
  output jvmos_pkg::dec_t dec
);

  always_comb begin
    dec = '0;
    unique case (operation)
      jvmos_pkg::OP_PUSH: begin
        dec.nout = 3'd1;
        dec.seq  = jvmos_pkg::SEQ_PUSH;
      end
      jvmos_pkg::OP_POP: begin
        dec.need = 3'd1;
      end
      jvmos_pkg::OP_POP2: begin
        dec.need = wide[0] ? 3'd1 : 3'd2;
      end
      jvmos_pkg::OP_DUP: begin
        dec.need = 3'd1;
        dec.nout = 3'd2;
        dec.seq  = jvmos_pkg::SEQ_DUP;
      end
      jvmos_pkg::OP_DUP_X1: begin
        dec.need = 3'd2;
        dec.nout = 3'd3;
        dec.seq  = jvmos_pkg::SEQ_X1;
      end
      jvmos_pkg::OP_DUP_X2: begin
        if (wide[1]) begin
          dec.need = 3'd2;
          dec.nout = 3'd3;
          dec.seq  = jvmos_pkg::SEQ_X1;
        end else begin
          dec.need = 3'd3;
          dec.nout = 3'd4;
          dec.seq  = jvmos_pkg::SEQ_X2;
        end
      end
      jvmos_pkg::OP_DUP2: begin
        if (wide[0]) begin
          dec.need = 3'd1;
          dec.nout = 3'd2;
          dec.seq  = jvmos_pkg::SEQ_DUP;
        end else begin
          dec.need = 3'd2;
          dec.nout = 3'd4;
          dec.seq  = jvmos_pkg::SEQ_PAIR;
        end
      end
      jvmos_pkg::OP_DUP2_X1: begin
        if (wide[0]) begin
          dec.need = 3'd2;
          dec.nout = 3'd3;
          dec.seq  = jvmos_pkg::SEQ_X1;
        end else begin
          dec.need = 3'd3;
          dec.nout = 3'd5;
          dec.seq  = jvmos_pkg::SEQ_PAIR_X1;
        end
      end
      jvmos_pkg::OP_DUP2_X2: begin
        if (wide[0] && wide[1]) begin
          dec.need = 3'd2;
          dec.nout = 3'd3;
          dec.seq  = jvmos_pkg::SEQ_X1;
        end else if (wide[0]) begin
          dec.need = 3'd3;
          dec.nout = 3'd4;
          dec.seq  = jvmos_pkg::SEQ_X2;
        end else if (wide[2]) begin
          dec.need = 3'd3;
          dec.nout = 3'd5;
          dec.seq  = jvmos_pkg::SEQ_PAIR_X1;
        end else begin
          dec.need = 3'd4;
          dec.nout = 3'd6;
          dec.seq  = jvmos_pkg::SEQ_PAIR_X2;
        end
      end
      jvmos_pkg::OP_SWAP: begin
        dec.need = 3'd2;
        dec.nout = 3'd2;
        dec.seq  = jvmos_pkg::SEQ_SWAP;
      end
      jvmos_pkg::OP_CLEAR: begin
        dec.clear = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

[rtl/jvmos_cell.sv]
// ----------------------------------------------------------------------------
// jvmos_cell: one stack entry
// Holds a value and its category flag. On an update it either takes a new
// entry from the top section, moves one or two places with the stack or holds.
// ----------------------------------------------------------------------------
module jvmos_cell #(
  parameter int VALUE_WIDTH = 64,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  jvmos_pkg::cell_ctl_t   ctl,
  input  logic [VALUE_WIDTH-1:0] fill_value,
  input  logic                   fill_wide,
  input  logic [VALUE_WIDTH-1:0] up1_value,
  input  logic                   up1_wide,
  input  logic [VALUE_WIDTH-1:0] up2_value,
  input  logic                   up2_wide,
  input  logic [VALUE_WIDTH-1:0] down1_value,
  input  logic                   down1_wide,
  input  logic [VALUE_WIDTH-1:0] down2_value,
  input  logic                   down2_wide,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   wide,
  output logic [VALUE_WIDTH-1:0] value_next,
  output logic                   wide_next
);

  localparam bit CAN_FILL = INDEX < jvmos_pkg::FILL_SLOTS;

  logic take_fill;

  assign take_fill = CAN_FILL && (ctl.fill_count > 3'(INDEX));

  always_comb begin
    value_next = value;
    wide_next  = wide;
    if (ctl.update) begin
      if (take_fill) begin
        value_next = fill_value;
        wide_next  = fill_wide;
      end else begin
        case (ctl.shift)
          jvmos_pkg::SH_DOWN1: begin
            value_next = up1_value;
            wide_next  = up1_wide;
          end
          jvmos_pkg::SH_DOWN2: begin
            value_next = up2_value;
            wide_next  = up2_wide;
          end
          jvmos_pkg::SH_UP1: begin
            value_next = down1_value;
            wide_next  = down1_wide;
          end
          jvmos_pkg::SH_UP2: begin
            value_next = down2_value;
            wide_next  = down2_wide;
          end
          default: begin
            value_next = value;
            wide_next  = wide;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    wide  <= wide_next;
  end

endmodule

[rtl/jvm_operand_stack_permute.sv]
// ----------------------------------------------------------------------------
// jvm_operand_stack_permute: JVM operand stack with category-aware rearrangement
// The stack is a row of entry cells with the top in the first cell.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and gives its result in the
// cycle after acceptance; the whole rearrangement of the top entries and the
// shift of the rest of the stack happen in a single update of the cell row,
// so the rate is set only by the result register, which accepts a new item
// whenever it is empty or being taken in the same cycle.
module jvm_operand_stack_permute #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  jvmos_pkg::cmd_item_t  cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output jvmos_pkg::rsp_item_t  rsp
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] cell_value      [STACK_DEPTH];
  logic                   cell_wide       [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_value_next [STACK_DEPTH];
  logic                   cell_wide_next  [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] head_value      [4];
  logic                   head_wide       [4];
  logic [VALUE_WIDTH-1:0] fill_value      [jvmos_pkg::FILL_SLOTS];
  logic                   fill_wide       [jvmos_pkg::FILL_SLOTS];

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW:0]         grown;
  logic [2:0]          wide_top;
  logic                accept;
  logic [1:0]          status;
  logic [3:0]          delta;
  jvmos_pkg::dec_t     dec;
  jvmos_pkg::cell_ctl_t ctl;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  for (genvar t = 0; t < 4; t++) begin : g_head
    assign head_value[t] = cell_value[t];
    assign head_wide[t]  = cell_wide[t];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_top[i] = (count > CW'(i)) && cell_wide[i];
    end
  end

  jvmos_decode u_decode (
    .operation (cmd.operation),
    .wide      (wide_top),
    .dec       (dec)
  );

  always_comb begin
    grown = (CW+1)'(count) + (CW+1)'(dec.nout) - (CW+1)'(dec.need);
    if (count < CW'(dec.need)) begin
      status = jvmos_pkg::ST_UNDER;
    end else if (grown > (CW+1)'(STACK_DEPTH)) begin
      status = jvmos_pkg::ST_OVER;
    end else begin
      status = jvmos_pkg::ST_OK;
    end
  end

  always_comb begin
    delta = {1'b0, dec.nout} - {1'b0, dec.need};
    ctl.update     = accept && (status == jvmos_pkg::ST_OK) && !dec.clear;
    ctl.fill_count = dec.nout;
    case (delta)
      4'd1:    ctl.shift = jvmos_pkg::SH_DOWN1;
      4'd2:    ctl.shift = jvmos_pkg::SH_DOWN2;
      4'hF:    ctl.shift = jvmos_pkg::SH_UP1;
      4'hE:    ctl.shift = jvmos_pkg::SH_UP2;
      default: ctl.shift = jvmos_pkg::SH_HOLD;
    endcase
  end

  always_comb begin
    for (int p = 0; p < jvmos_pkg::FILL_SLOTS; p++) begin
      fill_value[p] = head_value[jvmos_pkg::seq_src(dec.seq, 3'(p))];
      fill_wide[p]  = head_wide[jvmos_pkg::seq_src(dec.seq, 3'(p))];
    end
    if (dec.seq == jvmos_pkg::SEQ_PUSH) begin
      fill_value[0] = cmd.push_value[VALUE_WIDTH-1:0];
      fill_wide[0]  = cmd.push_is_wide;
    end
  end

  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
    logic [VALUE_WIDTH-1:0] f_value;
    logic                   f_wide;
    logic [VALUE_WIDTH-1:0] u1_value;
    logic                   u1_wide;
    logic [VALUE_WIDTH-1:0] u2_value;
    logic                   u2_wide;
    logic [VALUE_WIDTH-1:0] d1_value;
    logic                   d1_wide;
    logic [VALUE_WIDTH-1:0] d2_value;
    logic                   d2_wide;

    if (j < jvmos_pkg::FILL_SLOTS) begin : g_fill
      assign f_value = fill_value[j];
      assign f_wide  = fill_wide[j];
    end else begin : g_nofill
      assign f_value = '0;
      assign f_wide  = 1'b0;
    end

    if (j >= 1) begin : g_u1
      assign u1_value = cell_value[j-1];
      assign u1_wide  = cell_wide[j-1];
    end else begin : g_nu1
      assign u1_value = '0;
      assign u1_wide  = 1'b0;
    end

    if (j >= 2) begin : g_u2
      assign u2_value = cell_value[j-2];
      assign u2_wide  = cell_wide[j-2];
    end else begin : g_nu2
      assign u2_value = '0;
      assign u2_wide  = 1'b0;
    end

    if (j + 1 < STACK_DEPTH) begin : g_d1
      assign d1_value = cell_value[j+1];
      assign d1_wide  = cell_wide[j+1];
    end else begin : g_nd1
      assign d1_value = '0;
      assign d1_wide  = 1'b0;
    end

    if (j + 2 < STACK_DEPTH) begin : g_d2
      assign d2_value = cell_value[j+2];
      assign d2_wide  = cell_wide[j+2];
    end else begin : g_nd2
      assign d2_value = '0;
      assign d2_wide  = 1'b0;
    end

    jvmos_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (j)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .fill_value  (f_value),
      .fill_wide   (f_wide),
      .up1_value   (u1_value),
      .up1_wide    (u1_wide),
      .up2_value   (u2_value),
      .up2_wide    (u2_wide),
      .down1_value (d1_value),
      .down1_wide  (d1_wide),
      .down2_value (d2_value),
      .down2_wide  (d2_wide),
      .value       (cell_value[j]),
      .wide        (cell_wide[j]),
      .value_next  (cell_value_next[j]),
      .wide_next   (cell_wide_next[j])
    );
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      if (dec.clear) begin
        count_next = '0;
      end else if (status == jvmos_pkg::ST_OK) begin
        count_next = grown[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status <= status;
      rsp.depth  <= 7'(count_next);
      if (count_next == '0) begin
        rsp.top_value   <= '0;
        rsp.top_is_wide <= 1'b0;
      end else begin
        rsp.top_value   <= 64'(cell_value_next[0]);
        rsp.top_is_wide <= cell_wide_next[0];
      end
    end
  end

endmodule
